// ===== rtl/core/hrl_pkg.sv =====
`default_nettype none

package hrl_pkg;

  // Opcode values of the command field.
  typedef enum logic {
    OP_DIRECT = 1'b0,
    OP_HSV    = 1'b1
  } hrl_op_t;

  // Configuration register indexes.
  localparam logic REG_CHANNEL_ENABLE = 1'b0;

  localparam logic [2:0] CHANNEL_ENABLE_RESET = 3'd7;

  // Clamp limits and fixed-point constants of the HSV path.
  localparam logic [8:0] HUE_MAX     = 9'd359;
  localparam logic [8:0] HUE_FULL    = 9'd360;
  localparam logic [8:0] SECTOR_SPAN = 9'd60;
  localparam logic [6:0] PCT_MAX     = 7'd100;

  // Reciprocals: floor(x/360) = (x*RECIP_360) >> 24 for x up to 36000,
  // floor(x/100) = (x*RECIP_100) >> 20 for x up to 10000.
  localparam logic [15:0] RECIP_360       = 16'd46604;
  localparam int          RECIP_360_SHIFT = 24;
  localparam logic [13:0] RECIP_100       = 14'd10486;
  localparam int          RECIP_100_SHIFT = 20;

  typedef struct packed {
    logic        opcode;
    logic [23:0] color_word;
    logic [8:0]  hue;
    logic [6:0]  saturation;
    logic [6:0]  brightness_value;
  } hrl_cmd_t;

  typedef struct packed {
    logic [23:0] color_out;
    logic [6:0]  red_level;
    logic [6:0]  green_level;
    logic [6:0]  blue_level;
    logic [2:0]  drive_mask;
  } hrl_result_t;

  // Hand-off from the front half of the HSV pipe to the back half.
  typedef struct packed {
    logic        valid;
    logic        opcode;
    logic [23:0] color_word;
    logic [2:0]  sector;
    logic [6:0]  v;
    logic [6:0]  p;
    logic [6:0]  a;
    logic [6:0]  b;
  } hrl_front_t;

  // Hand-off from the back half to the output stage.
  typedef struct packed {
    logic        valid;
    logic        opcode;
    logic [23:0] color_word;
    logic [23:0] hsv_color;
  } hrl_back_t;

  typedef logic [7:0] pct_tbl_t [128];
  typedef logic [6:0] lvl_tbl_t [256];

  function automatic pct_tbl_t build_pct_tbl();
    pct_tbl_t tbl;
    for (int i = 0; i < 128; i++) begin
      tbl[i] = 8'((i * 255) / 100);
    end
    return tbl;
  endfunction

  function automatic lvl_tbl_t build_lvl_tbl();
    lvl_tbl_t tbl;
    for (int i = 0; i < 256; i++) begin
      tbl[i] = 7'((i * 100) / 255);
    end
    return tbl;
  endfunction

  // Percent to byte (x*255/100) and byte to level (x*100/255).
  localparam pct_tbl_t PCT_TO_BYTE = build_pct_tbl();
  localparam lvl_tbl_t BYTE_TO_LEVEL = build_lvl_tbl();

endpackage

`default_nettype wire

// ===== rtl/core/hrl_hsv_front.sv =====
`default_nettype none

module hrl_hsv_front
  import hrl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire hrl_cmd_t cmd,
  output hrl_front_t    front
);

  logic [8:0] hue_c;
  logic [6:0] sat_c;
  logic [6:0] val_c;
  logic [2:0] sector_c;
  logic [8:0] base_c;
  logic [5:0] diff_c;
  logic [8:0] rem_c;

  logic        s1_valid;
  logic        s1_opcode;
  logic [23:0] s1_color_word;
  logic [2:0]  s1_sector;
  logic [8:0]  s1_rem;
  logic [6:0]  s1_s;
  logic [6:0]  s1_v;

  logic        s2_valid;
  logic        s2_opcode;
  logic [23:0] s2_color_word;
  logic [2:0]  s2_sector;
  logic [6:0]  s2_v;
  logic [15:0] s2_prod_a;
  logic [15:0] s2_prod_b;
  logic [13:0] s2_pnum;

  logic [31:0] quot_a;
  logic [31:0] quot_b;
  logic [27:0] quot_p;

  // Clamp, then find the hue sector and the scaled remainder.
  always_comb begin
    hue_c = (cmd.hue > HUE_MAX) ? HUE_MAX : cmd.hue;
    sat_c = (cmd.saturation > PCT_MAX) ? PCT_MAX : cmd.saturation;
    val_c = (cmd.brightness_value > PCT_MAX) ? PCT_MAX : cmd.brightness_value;
    if (hue_c < SECTOR_SPAN) begin
      sector_c = 3'd0;
    end else if (hue_c < 9'(2 * SECTOR_SPAN)) begin
      sector_c = 3'd1;
    end else if (hue_c < 9'(3 * SECTOR_SPAN)) begin
      sector_c = 3'd2;
    end else if (hue_c < 9'(4 * SECTOR_SPAN)) begin
      sector_c = 3'd3;
    end else if (hue_c < 9'(5 * SECTOR_SPAN)) begin
      sector_c = 3'd4;
    end else begin
      sector_c = 3'd5;
    end
    base_c = 9'(sector_c * SECTOR_SPAN);
    diff_c = 6'(hue_c - base_c);
    rem_c  = 9'({diff_c, 2'b00}) + 9'({diff_c, 1'b0});
  end

  always_comb begin
    quot_a = 32'(s2_prod_a) * 32'(RECIP_360);
    quot_b = 32'(s2_prod_b) * 32'(RECIP_360);
    quot_p = 28'(s2_pnum) * 28'(RECIP_100);
  end

  // Only the valid bits are reset; the data registers simply follow them.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      front.valid <= 1'b0;
    end else begin
      s1_valid    <= in_valid;
      s2_valid    <= s1_valid;
      front.valid <= s2_valid;
    end

    s1_opcode     <= cmd.opcode;
    s1_color_word <= cmd.color_word;
    s1_sector     <= sector_c;
    s1_rem        <= rem_c;
    s1_s          <= sat_c;
    s1_v          <= val_c;

    s2_opcode     <= s1_opcode;
    s2_color_word <= s1_color_word;
    s2_sector     <= s1_sector;
    s2_v          <= s1_v;
    s2_prod_a     <= 16'(s1_s) * 16'(s1_rem);
    s2_prod_b     <= 16'(s1_s) * 16'(HUE_FULL - s1_rem);
    s2_pnum       <= 14'(s1_v) * 14'(PCT_MAX - s1_s);

    front.opcode     <= s2_opcode;
    front.color_word <= s2_color_word;
    front.sector     <= s2_sector;
    front.v          <= s2_v;
    front.a          <= 7'(quot_a >> RECIP_360_SHIFT);
    front.b          <= 7'(quot_b >> RECIP_360_SHIFT);
    front.p          <= 7'(quot_p >> RECIP_100_SHIFT);
  end

endmodule

`default_nettype wire

// ===== rtl/core/hrl_hsv_back.sv =====
`default_nettype none

module hrl_hsv_back
  import hrl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire hrl_front_t front,
  output hrl_back_t       back
);

  logic        s4_valid;
  logic        s4_opcode;
  logic [23:0] s4_color_word;
  logic [2:0]  s4_sector;
  logic [6:0]  s4_v;
  logic [6:0]  s4_p;
  logic [13:0] s4_qnum;
  logic [13:0] s4_tnum;

  logic        s5_valid;
  logic        s5_opcode;
  logic [23:0] s5_color_word;
  logic [2:0]  s5_sector;
  logic [6:0]  s5_v;
  logic [6:0]  s5_p;
  logic [6:0]  s5_q;
  logic [6:0]  s5_t;

  logic [27:0] quot_q;
  logic [27:0] quot_t;
  logic [7:0]  vs_c;
  logic [7:0]  pb_c;
  logic [7:0]  qb_c;
  logic [7:0]  tb_c;
  logic [23:0] rgb_c;

  always_comb begin
    quot_q = 28'(s4_qnum) * 28'(RECIP_100);
    quot_t = 28'(s4_tnum) * 28'(RECIP_100);
  end

  // Scale the percent terms to bytes and place them by hue sector.
  always_comb begin
    vs_c = PCT_TO_BYTE[s5_v];
    pb_c = PCT_TO_BYTE[s5_p];
    qb_c = PCT_TO_BYTE[s5_q];
    tb_c = PCT_TO_BYTE[s5_t];
    case (s5_sector)
      3'd0:    rgb_c = {vs_c, tb_c, pb_c};
      3'd1:    rgb_c = {qb_c, vs_c, pb_c};
      3'd2:    rgb_c = {pb_c, vs_c, tb_c};
      3'd3:    rgb_c = {pb_c, qb_c, vs_c};
      3'd4:    rgb_c = {tb_c, pb_c, vs_c};
      default: rgb_c = {vs_c, pb_c, qb_c};
    endcase
  end

  // Only the valid bits are reset; the data registers simply follow them.
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid   <= 1'b0;
      s5_valid   <= 1'b0;
      back.valid <= 1'b0;
    end else begin
      s4_valid   <= front.valid;
      s5_valid   <= s4_valid;
      back.valid <= s5_valid;
    end

    s4_opcode     <= front.opcode;
    s4_color_word <= front.color_word;
    s4_sector     <= front.sector;
    s4_v          <= front.v;
    s4_p          <= front.p;
    s4_qnum       <= 14'(front.v) * 14'(PCT_MAX - front.a);
    s4_tnum       <= 14'(front.v) * 14'(PCT_MAX - front.b);

    s5_opcode     <= s4_opcode;
    s5_color_word <= s4_color_word;
    s5_sector     <= s4_sector;
    s5_v          <= s4_v;
    s5_p          <= s4_p;
    s5_q          <= 7'(quot_q >> RECIP_100_SHIFT);
    s5_t          <= 7'(quot_t >> RECIP_100_SHIFT);

    back.opcode     <= s5_opcode;
    back.color_word <= s5_color_word;
    back.hsv_color  <= rgb_c;
  end

endmodule

`default_nettype wire

// ===== rtl/core/hrl_levels.sv =====
`default_nettype none

module hrl_levels
  import hrl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire hrl_back_t  back,
  input  wire logic [2:0] channel_enable,
  output logic            done,
  output hrl_result_t     result
);

  logic [23:0] color_c;

  // The selected color becomes the current color of the block.
  always_comb begin
    color_c = (back.opcode == OP_HSV) ? back.hsv_color : back.color_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= back.valid;
    end
  end

  always_ff @(posedge clk) begin
    result.color_out   <= color_c;
    result.red_level   <= BYTE_TO_LEVEL[color_c[23:16]];
    result.green_level <= BYTE_TO_LEVEL[color_c[15:8]];
    result.blue_level  <= BYTE_TO_LEVEL[color_c[7:0]];
    result.drive_mask  <= channel_enable;
  end

endmodule

`default_nettype wire

// ===== rtl/core/hsv_to_rgb_led_levels_core.sv =====
// Color setter for a three-channel LED.
// A command transaction is accepted at a rising edge where start is high and
// busy is low. The command either loads an RGB888 color word directly or gives
// hue, saturation and value, which are clamped and converted with integer
// percent arithmetic. Every command produces exactly one result transaction.
// The result carries the new color, three channel levels (byte*100/255) and
// the mask of driven channels taken from the channel_enable register.
// done is high for one cycle once a command has passed the seven register stages
// of the pipe (sector split, products,
// reciprocal divides, two more product and divide stages, byte scaling, and
// the output register). Throughput is one command per cycle; busy stays low.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset is synchronous and active high; it empties the pipe (no done strobe
// until a new command arrives) and sets channel_enable to all channels.
// channel_enable sits at byte address 0 of the APB port; pready is always high
// and a write takes effect at the access edge.
`default_nettype none

module hsv_to_rgb_led_levels_core
  import hrl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire hrl_cmd_t    cmd,
  output logic             done,
  output hrl_result_t      result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [2:0] channel_enable;
  logic       cfg_write;
  logic       in_valid;
  hrl_front_t front;
  hrl_back_t  back;

  // The pipe takes a command every cycle, so it never reports busy.
  assign busy     = 1'b0;
  assign pready   = 1'b1;
  assign in_valid = start & ~busy;

  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_enable <= CHANNEL_ENABLE_RESET;
    end else if (cfg_write && paddr[2] == REG_CHANNEL_ENABLE) begin
      channel_enable <= pwdata[2:0];
    end
  end

  // Only the single register decodes, on paddr[2] alone; addresses with paddr[2] set read as zero.
  always_comb begin
    if (paddr[2] == REG_CHANNEL_ENABLE) begin
      prdata = {29'd0, channel_enable};
    end else begin
      prdata = 32'd0;
    end
  end

  hrl_hsv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .front    (front)
  );

  hrl_hsv_back u_back (
    .clk   (clk),
    .rst   (rst),
    .front (front),
    .back  (back)
  );

  hrl_levels u_levels (
    .clk            (clk),
    .rst            (rst),
    .back           (back),
    .channel_enable (channel_enable),
    .done           (done),
    .result         (result)
  );

endmodule

`default_nettype wire

// ===== tb/hsv_to_rgb_led_levels_core_tb.sv =====
`default_nettype none

// Testbench for the HSV/RGB color setter of a three-channel LED.
// Commands go in through the start/busy handshake and every accepted command
// must produce exactly one result transaction on the done strobe. The bench
// keeps its own model of the color conversion, the level scaling and the
// channel_enable register. It predicts each result when the command is
// accepted and compares the results in order as they come out.
module hsv_to_rgb_led_levels_core_tb;
  import hrl_pkg::*;

  // Extra wait once the last expected result has arrived, longer than the pipe
  // is deep, so that the block is idle.
  localparam int PIPE_SETTLE     = 10;
  localparam int DRAIN_LIMIT     = 200;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int NUM_DIRECTED    = 20;
  localparam int IDLE_PERCENT    = 17;

  // One row of the directed table. When has_known is set, the expected result
  // is typed into the row. Otherwise the predictor supplies it.
  typedef struct {
    hrl_cmd_t    cmd;
    bit          has_known;
    hrl_result_t known;
  } led_vector_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  hrl_cmd_t    cmd = '0;
  logic        done;
  hrl_result_t result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // These mirror the block's state: the register copy and the current color.
  logic [2:0]  enable_mirror = CHANNEL_ENABLE_RESET;
  logic [23:0] current_color_mirror = '0;

  hrl_result_t pending_results[$];
  int          mismatch_count = 0;
  bit          sender_idles = 1'b1;

  led_vector_t directed_vectors[NUM_DIRECTED];

  hsv_to_rgb_led_levels_core DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always #1 clk = ~clk;

  // The whole run is bounded. A hung handshake ends up here.
  initial begin
    #400000;
    $display("[hsv_to_rgb_led_levels_core] ERROR");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  function automatic int unsigned pct_to_byte(input int unsigned x);
    return (x * 255) / 100;
  endfunction

  function automatic logic [6:0] byte_to_pct(input logic [7:0] x);
    return 7'((int'(x) * 100) / 255);
  endfunction

  // Integer-percent HSV conversion. The inputs are clamped first. Zero
  // saturation is pure grey. Otherwise the hue picks one of six sectors and
  // the falling (q) and rising (t) terms are interpolated across it.
  function automatic logic [23:0] hsv_to_color(input int unsigned h, input int unsigned s,
                                               input int unsigned v);
    int unsigned sector, rem, vs, p, q, t, r, g, b;
    if (h >= HUE_FULL) h = 32'(HUE_MAX);
    if (s > PCT_MAX) s = 32'(PCT_MAX);
    if (v > PCT_MAX) v = 32'(PCT_MAX);
    vs = pct_to_byte(v);
    if (s == 0) return {vs[7:0], vs[7:0], vs[7:0]};
    sector = h / SECTOR_SPAN;
    rem = (h - sector * SECTOR_SPAN) * 6;
    p = pct_to_byte((v * (100 - s)) / 100);
    q = pct_to_byte((v * (100 - (s * rem) / HUE_FULL)) / 100);
    t = pct_to_byte((v * (100 - (s * (HUE_FULL - rem)) / HUE_FULL)) / 100);
    case (sector)
      0: begin r = vs; g = t;  b = p;  end
      1: begin r = q;  g = vs; b = p;  end
      2: begin r = p;  g = vs; b = t;  end
      3: begin r = p;  g = q;  b = vs; end
      4: begin r = t;  g = p;  b = vs; end
      default: begin r = vs; g = p; b = q; end
    endcase
    return {r[7:0], g[7:0], b[7:0]};
  endfunction

  // Computes the result of one accepted command and moves the mirrored
  // current color along. Disabled channels still get their level computed.
  // Only drive_mask shows that they are not applied.
  function automatic hrl_result_t predict_led_result(input hrl_cmd_t c);
    hrl_result_t res;
    if (c.opcode == OP_DIRECT) current_color_mirror = c.color_word;
    else current_color_mirror = hsv_to_color(32'(c.hue), 32'(c.saturation),
                                             32'(c.brightness_value));
    res.color_out   = current_color_mirror;
    res.red_level   = byte_to_pct(current_color_mirror[23:16]);
    res.green_level = byte_to_pct(current_color_mirror[15:8]);
    res.blue_level  = byte_to_pct(current_color_mirror[7:0]);
    res.drive_mask  = enable_mirror;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Result checking: every done strobe is matched against the oldest
  // expectation, field by field.
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    hrl_result_t exp;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result color %06h", result.color_out));
      end else begin
        exp = pending_results.pop_front();
        if (result.color_out !== exp.color_out)
          report_mismatch($sformatf("color_out %06h, expected %06h",
                                    result.color_out, exp.color_out));
        if (result.red_level !== exp.red_level)
          report_mismatch($sformatf("red_level %0d, expected %0d",
                                    result.red_level, exp.red_level));
        if (result.green_level !== exp.green_level)
          report_mismatch($sformatf("green_level %0d, expected %0d",
                                    result.green_level, exp.green_level));
        if (result.blue_level !== exp.blue_level)
          report_mismatch($sformatf("blue_level %0d, expected %0d",
                                    result.blue_level, exp.blue_level));
        if (result.drive_mask !== exp.drive_mask)
          report_mismatch($sformatf("drive_mask %0d, expected %0d",
                                    result.drive_mask, exp.drive_mask));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // Offers one command and returns after the edge that accepts it. The start
  // line is only set here or in settle_pipe, and always at a falling edge.
  // This keeps back-to-back commands from lowering and raising it in one step.
  task automatic issue_cmd(input hrl_cmd_t c, input bit has_known, input hrl_result_t known);
    hrl_result_t predicted;
    @(negedge clk);
    while (sender_idles && $urandom_range(99) < IDLE_PERCENT) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    predicted = predict_led_result(c);
    pending_results.push_back(has_known ? known : predicted);
  endtask

  // Stops the command stream and waits until every expected result has
  // arrived. It then gives the pipe a few more cycles to empty completely.
  // An expectation still waiting after that is a failure.
  task automatic settle_pipe();
    int waited;
    waited = 0;
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_SETTLE) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
      pending_results.delete();
    end
  endtask

  // One APB transaction: a setup cycle, then an access cycle that completes
  // at the rising edge where pready is high. Read data is taken at that edge.
  task automatic apb_access(input bit wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {REG_CHANNEL_ENABLE, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr) enable_mirror = wdata[2:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Writes channel_enable and reads it back.
  task automatic set_channel_enable(input logic [2:0] mask);
    logic [31:0] rd;
    apb_access(1'b1, {29'd0, mask}, rd);
    apb_access(1'b0, '0, rd);
    if (rd[2:0] !== mask)
      report_mismatch($sformatf("channel_enable reads %0d, expected %0d", rd[2:0], mask));
  endtask

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  function automatic led_vector_t vec(input hrl_op_t op, input logic [23:0] word,
                                      input logic [8:0] h, input logic [6:0] s,
                                      input logic [6:0] v, input bit has_known,
                                      input logic [23:0] color, input logic [6:0] rl,
                                      input logic [6:0] gl, input logic [6:0] bl);
    led_vector_t row;
    row.cmd = '{opcode: op, color_word: word, hue: h, saturation: s,
                brightness_value: v};
    row.has_known = has_known;
    row.known = '{color_out: color, red_level: rl, green_level: gl,
                  blue_level: bl, drive_mask: CHANNEL_ENABLE_RESET};
    return row;
  endfunction

  // Random command with random content. Most HSV fields stay in range,
  // but some go up to the full field width to exercise the clamps.
  // Saturation is zero now and then to hit the grey path.
  function automatic hrl_cmd_t random_cmd();
    hrl_cmd_t c;
    c.opcode     = 1'($urandom_range(1));
    c.color_word = 24'($urandom);
    c.hue        = ($urandom_range(9) == 0) ? 9'($urandom_range(511))
                                            : 9'($urandom_range(359));
    case ($urandom_range(9))
      0:       c.saturation = '0;
      1:       c.saturation = 7'($urandom_range(127));
      default: c.saturation = 7'($urandom_range(100));
    endcase
    c.brightness_value = ($urandom_range(9) == 0) ? 7'($urandom_range(127))
                                                  : 7'($urandom_range(100));
    return c;
  endfunction

  // The masks of the random phases. Both extremes are included, and the
  // reset value is written back explicitly.
  logic [2:0] phase_masks[NUM_PHASES] = '{3'd0, 3'd7, 3'd5, 3'd2, 3'd1, 3'd6, 3'd4, 3'd3};

  initial begin
    hrl_result_t none;
    none = '0;

    // Directed rows. Pure colors and greys at full scale have expected
    // results that are obvious. Clamped, fractional and ignored-field cases
    // are left to the predictor.
    directed_vectors[0]  = vec(OP_DIRECT, 24'h000000, 9'd0,   7'd0,   7'd0,   1,
                               24'h000000, 7'd0,   7'd0,   7'd0);
    directed_vectors[1]  = vec(OP_DIRECT, 24'hFFFFFF, 9'd0,   7'd0,   7'd0,   1,
                               24'hFFFFFF, 7'd100, 7'd100, 7'd100);
    directed_vectors[2]  = vec(OP_HSV,    24'h000000, 9'd0,   7'd0,   7'd0,   1,
                               24'h000000, 7'd0,   7'd0,   7'd0);
    directed_vectors[3]  = vec(OP_HSV,    24'h000000, 9'd0,   7'd0,   7'd100, 1,
                               24'hFFFFFF, 7'd100, 7'd100, 7'd100);
    directed_vectors[4]  = vec(OP_HSV,    24'h000000, 9'd0,   7'd100, 7'd100, 1,
                               24'hFF0000, 7'd100, 7'd0,   7'd0);
    directed_vectors[5]  = vec(OP_HSV,    24'h000000, 9'd60,  7'd100, 7'd100, 1,
                               24'hFFFF00, 7'd100, 7'd100, 7'd0);
    directed_vectors[6]  = vec(OP_HSV,    24'h000000, 9'd120, 7'd100, 7'd100, 1,
                               24'h00FF00, 7'd0,   7'd100, 7'd0);
    directed_vectors[7]  = vec(OP_HSV,    24'h000000, 9'd180, 7'd100, 7'd100, 1,
                               24'h00FFFF, 7'd0,   7'd100, 7'd100);
    directed_vectors[8]  = vec(OP_HSV,    24'h000000, 9'd240, 7'd100, 7'd100, 1,
                               24'h0000FF, 7'd0,   7'd0,   7'd100);
    directed_vectors[9]  = vec(OP_HSV,    24'h000000, 9'd300, 7'd100, 7'd100, 1,
                               24'hFF00FF, 7'd100, 7'd0,   7'd100);
    // Top of the hue range, and the clamps on hue, saturation and value.
    directed_vectors[10] = vec(OP_HSV,    24'h000000, 9'd359, 7'd100, 7'd100, 0,
                               '0, '0, '0, '0);
    directed_vectors[11] = vec(OP_HSV,    24'h000000, 9'd360, 7'd50,  7'd50,  0,
                               '0, '0, '0, '0);
    directed_vectors[12] = vec(OP_HSV,    24'h000000, 9'd511, 7'd127, 7'd127, 0,
                               '0, '0, '0, '0);
    directed_vectors[13] = vec(OP_HSV,    24'h000000, 9'd30,  7'd101, 7'd127, 0,
                               '0, '0, '0, '0);
    directed_vectors[14] = vec(OP_HSV,    24'h000000, 9'd0,   7'd127, 7'd0,   0,
                               '0, '0, '0, '0);
    // In the next two rows, fields that the opcode does not use are all ones and must be ignored.
    directed_vectors[15] = vec(OP_DIRECT, 24'h123456, 9'h1FF, 7'h7F,  7'h7F,  0,
                               '0, '0, '0, '0);
    directed_vectors[16] = vec(OP_HSV,    24'hFFFFFF, 9'd200, 7'd75,  7'd60,  0,
                               '0, '0, '0, '0);
    directed_vectors[17] = vec(OP_DIRECT, 24'h800180, 9'd0,   7'd0,   7'd0,   0,
                               '0, '0, '0, '0);
    directed_vectors[18] = vec(OP_HSV,    24'h000000, 9'd59,  7'd1,   7'd1,   0,
                               '0, '0, '0, '0);
    directed_vectors[19] = vec(OP_HSV,    24'h000000, 9'd1,   7'd100, 7'd100, 0,
                               '0, '0, '0, '0);

    // Reset is held from the start and released at a falling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The register must read back its reset value before any write.
    begin
      logic [31:0] rd;
      apb_access(1'b0, '0, rd);
      if (rd[2:0] !== CHANNEL_ENABLE_RESET)
        report_mismatch($sformatf("channel_enable after reset %0d", rd[2:0]));
    end

    foreach (directed_vectors[i])
      issue_cmd(directed_vectors[i].cmd, directed_vectors[i].has_known,
                directed_vectors[i].known);
    settle_pipe();

    // Random phases. Each one starts with a register write on an idle block.
    // Phase 3 runs with no sender gaps, which gives a long back-to-back
    // stretch. Halfway through phase 1, the sender stops until the pipe
    // has emptied completely.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_channel_enable(phase_masks[ph]);
      sender_idles = (ph != 3);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 1 && n == ITEMS_PER_PHASE / 2) settle_pipe();
        issue_cmd(random_cmd(), 1'b0, none);
      end
      settle_pipe();
    end

    if (mismatch_count == 0) begin
      $display("[hsv_to_rgb_led_levels_core] OK");
    end else begin
      $display("[hsv_to_rgb_led_levels_core] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
